>>> design/olist_pkg.sv
`default_nettype none

package olist_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_REMOVE     = 2'd2,
        OP_DUMP       = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_DONE      = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_NOT_FOUND = 3'd2,
        KIND_ELEMENT   = 3'd3,
        KIND_END       = 3'd4
    } t_kind;

    typedef struct packed {
        logic                     valid;
        t_kind                    kind;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } t_res;

endpackage

`default_nettype wire

>>> design/ordered_value_list.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_stall   i_operation, i_value
// result    out        o_out_valid / i_out_stall o_kind, o_element, o_last
//
// A push to the back, a push into a full list and any request on an empty list go
// straight to the response. A push to the front moves each entry up from the back,
// then writes the head; a removal compares each entry and moves those after a match
// down; a dump gives one element per read, all via the memory's single read port.
// Synchronous active-low reset empties the list; no memory sweep is needed.
// A stalled result holds the block in its current step until it is taken.
module ordered_value_list #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [1:0]                          i_operation,
    input  wire logic signed [olist_pkg::DATA_W-1:0] i_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [2:0]                               o_kind,
    output logic signed [olist_pkg::DATA_W-1:0]      o_element,
    output logic                                     o_last
);
    import olist_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    t_res               res;
    logic               res_ready;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [DATA_W-1:0]  rd_data;

    logic                     r_out_valid;
    logic [2:0]               r_kind;
    logic signed [DATA_W-1:0] r_element;
    logic                     r_last;

    assign res_ready = !r_out_valid || !i_out_stall;

    olist_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    olist_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready) begin
            r_kind    <= res.kind;
            r_element <= res.element;
            r_last    <= res.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_element   = r_element;
    assign o_last      = r_last;

endmodule

`default_nettype wire

>>> design/olist_mem.sv
`default_nettype none

module olist_mem #(
    parameter int DEPTH = olist_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_wr_en,
    input  wire logic [AW-1:0]                   i_wr_addr,
    input  wire logic [olist_pkg::DATA_W-1:0]    i_wr_data,
    input  wire logic                            i_rd_en,
    input  wire logic [AW-1:0]                   i_rd_addr,
    output logic      [olist_pkg::DATA_W-1:0]    o_rd_data
);
    import olist_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/olist_ctrl.sv
`default_nettype none

module olist_ctrl #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [1:0]                          i_operation,
    input  wire logic signed [olist_pkg::DATA_W-1:0] i_value,
    input  wire logic                                i_res_ready,
    output olist_pkg::t_res                          o_res,
    output logic                                     o_wr_en,
    output logic [AW-1:0]                            o_wr_addr,
    output logic [olist_pkg::DATA_W-1:0]             o_wr_data,
    output logic                                     o_rd_en,
    output logic [AW-1:0]                            o_rd_addr,
    input  wire logic [olist_pkg::DATA_W-1:0]        i_rd_data
);
    import olist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_L = CW'(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_FRONT = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [DATA_W-1:0] r_val, n_val;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_count, n_count;
    logic              r_found, n_found;
    t_kind             r_kind, n_kind;

    logic              accept;
    logic              full;
    logic              match;
    logic              at_end;
    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     idx_dec;
    logic [CW-1:0]     last_idx;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CAP_L);
    assign match      = (i_rd_data == r_val);
    assign idx_inc    = r_idx + 1'b1;
    assign idx_dec    = r_idx - 1'b1;
    assign last_idx   = r_count - 1'b1;
    assign at_end     = (r_idx == last_idx);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_val     = r_val;
        n_idx     = r_idx;
        n_count   = r_count;
        n_found   = r_found;
        n_kind    = r_kind;
        o_wr_en   = 1'b0;
        o_wr_addr = '0;
        o_wr_data = r_val;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx[AW-1:0];
        o_res     = '{valid: 1'b0, kind: KIND_DONE, element: '0, last: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op    = t_op'(i_operation);
                    n_val   = i_value;
                    n_idx   = '0;
                    n_found = 1'b0;
                    unique case (t_op'(i_operation)) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (full) begin
                                n_kind  = KIND_FULL;
                                n_state = S_RESP;
                            end else if (t_op'(i_operation) == OP_PUSH_BACK
                                         || r_count == '0) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = r_count[AW-1:0];
                                o_wr_data = i_value;
                                n_count   = r_count + 1'b1;
                                n_kind    = KIND_DONE;
                                n_state   = S_RESP;
                            end else begin
                                n_idx   = last_idx;
                                n_state = S_READ;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_kind  = KIND_NOT_FOUND;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_kind  = KIND_END;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                o_rd_en = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                unique case (r_op)
                    OP_PUSH_FRONT: begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = idx_inc[AW-1:0];
                        o_wr_data = i_rd_data;
                        if (r_idx == '0) begin
                            n_state = S_FRONT;
                        end else begin
                            n_idx   = idx_dec;
                            n_state = S_READ;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_found) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = idx_dec[AW-1:0];
                            o_wr_data = i_rd_data;
                        end else if (match) begin
                            n_found = 1'b1;
                        end
                        if (at_end) begin
                            if (r_found || match) begin
                                n_count = last_idx;
                                n_kind  = KIND_DONE;
                            end else begin
                                n_kind  = KIND_NOT_FOUND;
                            end
                            n_state = S_RESP;
                        end else begin
                            n_idx   = idx_inc;
                            n_state = S_READ;
                        end
                    end
                    OP_DUMP: begin
                        if (i_res_ready) begin
                            o_res = '{valid: 1'b1, kind: KIND_ELEMENT,
                                      element: i_rd_data, last: 1'b0};
                            if (at_end) begin
                                n_kind  = KIND_END;
                                n_state = S_RESP;
                            end else begin
                                n_idx   = idx_inc;
                                n_state = S_READ;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FRONT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = '0;
                o_wr_data = r_val;
                n_count   = r_count + 1'b1;
                n_kind    = KIND_DONE;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (i_res_ready) begin
                    o_res   = '{valid: 1'b1, kind: r_kind, element: '0, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_val   <= n_val;
        r_idx   <= n_idx;
        r_found <= n_found;
        r_kind  <= n_kind;
    end

    // The list never holds more entries than the storage has rows.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_L)
        else $error("entry count above capacity");

    // Every write lands inside the occupied part of the list or just past it.
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (CW'(o_wr_addr) <= r_count))
        else $error("write beyond the end of the list");

    // A push at the back into a list with room grows it by exactly one entry.
    a_push_back_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_op'(i_operation) == OP_PUSH_BACK && !full)
            |=> (r_count == $past(r_count) + 1'b1))
        else $error("push at back did not grow the list");

    // A status result always closes the request and the block is idle after it.
    a_resp_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |=> (r_state == S_IDLE))
        else $error("final result did not end the request");

endmodule

`default_nettype wire
